>>> design/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_APPEND = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_READ   = 3'd5
  } lkv_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } lkv_status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } lkv_fsm_t;

  // Per-cell write controls
  typedef struct packed {
    logic load;
    logic update;
    logic shift;
  } lkv_cell_ctl_t;

endpackage

`default_nettype wire

>>> design/lkv_cell.sv
`default_nettype none

module lkv_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int NUM_BITS   = 4
) (
  input  wire                         clk,
  input  wire                         cmp_en,
  input  wire                         active,
  input  wire  [KEY_BITS-1:0]         cmp_key,
  input  wire  lkv_pkg::lkv_cell_ctl_t ctl,
  input  wire  [KEY_BITS-1:0]         new_key,
  input  wire  [VALUE_BITS-1:0]       new_val,
  input  wire  [NUM_BITS-1:0]         new_num,
  input  wire  [KEY_BITS-1:0]         nb_key,
  input  wire  [VALUE_BITS-1:0]       nb_val,
  input  wire  [NUM_BITS-1:0]         nb_num,
  input  wire                         hit_in,
  output logic                        hit_out,
  output logic                        first,
  output logic [KEY_BITS-1:0]         key,
  output logic [VALUE_BITS-1:0]       val,
  output logic [NUM_BITS-1:0]         num
);
  import lkv_pkg::*;

  logic [KEY_BITS-1:0]   key_r,   key_nxt;
  logic [VALUE_BITS-1:0] val_r,   val_nxt;
  logic [NUM_BITS-1:0]   num_r,   num_nxt;
  logic                  match_r, match_nxt;

  always_comb begin
    match_nxt = cmp_en ? (active && (key_r == cmp_key)) : match_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    num_nxt   = num_r;
    if (ctl.load) begin
      key_nxt = new_key;
      val_nxt = new_val;
      num_nxt = new_num;
    end else if (ctl.update) begin
      val_nxt = new_val;
    end else if (ctl.shift) begin
      // take the entry of the next slot up
      key_nxt = nb_key;
      val_nxt = nb_val;
      num_nxt = nb_num;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    num_r   <= num_nxt;
  end

  // hit_out: some slot at or below this one matched
  assign hit_out = hit_in | match_r;
  assign first   = match_r & ~hit_in;
  assign key     = key_r;
  assign val     = val_r;
  assign num     = num_r;

endmodule

`default_nettype wire

>>> design/linear_key_value_table.sv
// Operation: at input transfer every cell compares its key with the input key;
// the execute state then picks the first match and applies the operation.
// A new item is taken only after the execute state of the last one, and a
// result held by out_stall delays the next execute.
// Reset (synchronous, rst_n low) empties the table and drops any result.
`default_nettype none

module linear_key_value_table #(
  parameter int DEPTH      = lkv_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [2:0]                         in_opcode,
  input  wire  [KEY_BITS-1:0]                in_key_in,
  input  wire  [VALUE_BITS-1:0]              in_value_in,
  input  wire  [$clog2(DEPTH)-1:0]           in_position,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         out_status,
  output logic                               out_found,
  output logic [KEY_BITS-1:0]                out_key_out,
  output logic [VALUE_BITS-1:0]              out_value_out,
  output logic [$clog2(DEPTH)-1:0]           out_insert_number,
  output logic [$clog2(DEPTH+1)-1:0]         out_entry_count
);
  import lkv_pkg::*;

  localparam int NUM_BITS = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);

  lkv_fsm_t state_r, state_nxt;

  logic [2:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [NUM_BITS-1:0]   pos_r;
  logic [CW-1:0]         count_r, count_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            status_r;
  logic                  found_r;
  logic [KEY_BITS-1:0]   okey_r;
  logic [VALUE_BITS-1:0] oval_r;
  logic [NUM_BITS-1:0]   onum_r;

  logic accept, exec_go;
  logic do_append, do_update, do_shift;

  logic [DEPTH:0]        hit_chain;
  logic [DEPTH-1:0]      first_v, sel_v;
  logic [KEY_BITS-1:0]   ck   [DEPTH];
  logic [VALUE_BITS-1:0] cv   [DEPTH];
  logic [NUM_BITS-1:0]   cn   [DEPTH];

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [NUM_BITS-1:0]   rd_num;

  logic [1:0]            res_status;
  logic                  res_found;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_val;
  logic [NUM_BITS-1:0]   res_num;

  logic any_hit, full, is_read;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_EXEC;
      FSM_EXEC: if (exec_go)  state_nxt = FSM_IDLE;
      default:                state_nxt = FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    exec_go  = 1'b0;
    unique case (state_r)
      // hold off transfers while in reset
      FSM_IDLE: in_stall = !rst_n;
      FSM_EXEC: exec_go  = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= in_key_in;
      val_r <= in_value_in;
      pos_r <= in_position;
    end
    if (exec_go) begin
      status_r <= res_status;
      found_r  <= res_found;
      okey_r   <= res_key;
      oval_r   <= res_val;
      onum_r   <= res_num;
    end
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lkv_cell_ctl_t ctl;
    logic          active;

    assign active     = count_r > CW'(i);
    assign ctl.load   = do_append && (count_r == CW'(i));
    assign ctl.update = do_update && first_v[i];
    assign ctl.shift  = do_shift && hit_chain[i+1];
    assign sel_v[i]   = is_read ? (pos_r == NUM_BITS'(i)) : first_v[i];

    if (i == DEPTH - 1) begin : g_last
      lkv_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .NUM_BITS   (NUM_BITS)
      ) u_cell (
        .clk     (clk),
        .cmp_en  (accept),
        .active  (active),
        .cmp_key (in_key_in),
        .ctl     (ctl),
        .new_key (key_r),
        .new_val (val_r),
        .new_num (count_r[NUM_BITS-1:0]),
        .nb_key  (ck[i]),
        .nb_val  (cv[i]),
        .nb_num  (cn[i]),
        .hit_in  (hit_chain[i]),
        .hit_out (hit_chain[i+1]),
        .first   (first_v[i]),
        .key     (ck[i]),
        .val     (cv[i]),
        .num     (cn[i])
      );
    end else begin : g_mid
      lkv_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .NUM_BITS   (NUM_BITS)
      ) u_cell (
        .clk     (clk),
        .cmp_en  (accept),
        .active  (active),
        .cmp_key (in_key_in),
        .ctl     (ctl),
        .new_key (key_r),
        .new_val (val_r),
        .new_num (count_r[NUM_BITS-1:0]),
        .nb_key  (ck[i+1]),
        .nb_val  (cv[i+1]),
        .nb_num  (cn[i+1]),
        .hit_in  (hit_chain[i]),
        .hit_out (hit_chain[i+1]),
        .first   (first_v[i]),
        .key     (ck[i]),
        .val     (cv[i]),
        .num     (cn[i])
      );
    end
  end

  // one-hot select of the entry to report
  always_comb begin
    rd_key = '0;
    rd_val = '0;
    rd_num = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_key = rd_key | (ck[i] & {KEY_BITS{sel_v[i]}});
      rd_val = rd_val | (cv[i] & {VALUE_BITS{sel_v[i]}});
      rd_num = rd_num | (cn[i] & {NUM_BITS{sel_v[i]}});
    end
  end

  assign any_hit = hit_chain[DEPTH];
  assign full    = count_r == CW'(DEPTH);
  assign is_read = op_r == OP_READ;

  // operation decode
  always_comb begin
    do_append  = 1'b0;
    do_update  = 1'b0;
    do_shift   = 1'b0;
    count_nxt  = count_r;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_key    = '0;
    res_val    = '0;
    res_num    = '0;
    unique case (op_r)
      OP_STORE, OP_APPEND: begin
        if (op_r == OP_STORE && any_hit) begin
          do_update = exec_go;
          res_found = 1'b1;
          res_key   = rd_key;
          res_val   = val_r;
          res_num   = rd_num;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_append = exec_go;
          res_key   = key_r;
          res_val   = val_r;
          res_num   = count_r[NUM_BITS-1:0];
          if (exec_go) count_nxt = count_r + CW'(1);
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        if (any_hit) begin
          res_found = 1'b1;
          res_key   = rd_key;
          res_val   = rd_val;
          res_num   = rd_num;
          if (op_r == OP_DELETE) begin
            do_shift = exec_go;
            if (exec_go) count_nxt = count_r - CW'(1);
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        if (exec_go) count_nxt = '0;
      end
      OP_READ: begin
        if (CW'(pos_r) < count_r) begin
          res_found = 1'b1;
          res_key   = rd_key;
          res_val   = rd_val;
          res_num   = rd_num;
        end else begin
          res_status = ST_BEYOND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // entry_count reports the count after the operation, i.e. the current one
  logic [CW-1:0] ocount_r;
  always_ff @(posedge clk) begin
    if (exec_go) ocount_r <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found         = found_r;
  assign out_key_out       = okey_r;
  assign out_value_out     = oval_r;
  assign out_insert_number = onum_r;
  assign out_entry_count   = ocount_r;

endmodule

`default_nettype wire

>>> tb/tb_linear_key_value_table.sv
`default_nettype none

module tb_linear_key_value_table;
  import lkv_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int KEY_POOL = 12;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    lkv_status_t status;
    logic        found;
    logic [31:0] key;
    logic [31:0] value;
    logic [3:0]  number;
    logic [4:0]  count;
  } kv_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = 3'd0;
  logic [31:0] in_key_in = 32'd0;
  logic [31:0] in_value_in = 32'd0;
  logic [3:0]  in_position = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [31:0] out_key_out;
  logic [31:0] out_value_out;
  logic [3:0]  out_insert_number;
  logic [4:0]  out_entry_count;

  // Table mirror
  logic [31:0] tbl_key [DEPTH];
  logic [31:0] tbl_val [DEPTH];
  logic [3:0]  tbl_num [DEPTH];
  int          tbl_count = 0;

  kv_result_t  expected_q [$];
  kv_result_t  exp_head;
  logic [31:0] key_pool [KEY_POOL];
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;
  int          err_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          full_rejects = 0;
  int          delete_hits = 0;
  int          quiet_cycles = 0;

  linear_key_value_table uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_key_in         (in_key_in),
    .in_value_in       (in_value_in),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_key_out       (out_key_out),
    .out_value_out     (out_value_out),
    .out_insert_number (out_insert_number),
    .out_entry_count   (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_key(logic [31:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int add_entry(logic [31:0] key, logic [31:0] val);
    int slot;
    if (tbl_count >= DEPTH) return -1;
    slot = tbl_count;
    tbl_key[slot] = key;
    tbl_val[slot] = val;
    tbl_num[slot] = slot[3:0];
    tbl_count++;
    return slot;
  endfunction

  function automatic kv_result_t entry_result(lkv_status_t st, logic fnd, int slot);
    kv_result_t r;
    r = '0;
    r.status = st;
    r.found = fnd;
    r.key = tbl_key[slot];
    r.value = tbl_val[slot];
    r.number = tbl_num[slot];
    return r;
  endfunction

  // Apply one operation to the mirror and return the result it should give.
  function automatic kv_result_t table_apply(logic [2:0] op, logic [31:0] key,
                                             logic [31:0] val, logic [3:0] pos);
    kv_result_t r;
    int hit;
    int slot;
    r = '0;
    r.status = ST_OK;
    hit = find_key(key);
    case (op)
      OP_STORE: begin
        if (hit >= 0) begin
          tbl_val[hit] = val;
          r = entry_result(ST_OK, 1'b1, hit);
        end else begin
          slot = add_entry(key, val);
          if (slot >= 0) r = entry_result(ST_OK, 1'b0, slot);
          else r.status = ST_FULL;
        end
      end
      OP_APPEND: begin
        slot = add_entry(key, val);
        if (slot >= 0) r = entry_result(ST_OK, 1'b0, slot);
        else r.status = ST_FULL;
      end
      OP_LOOKUP: begin
        if (hit >= 0) r = entry_result(ST_OK, 1'b1, hit);
        else r.status = ST_NOT_FOUND;
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          r = entry_result(ST_OK, 1'b1, hit);
          // shift later entries down, keep their insertion numbers
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_val[j] = tbl_val[j + 1];
            tbl_num[j] = tbl_num[j + 1];
          end
          tbl_count--;
          delete_hits++;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: tbl_count = 0;
      OP_READ: begin
        if (pos < tbl_count) r = entry_result(ST_OK, 1'b1, int'(pos));
        else r.status = ST_BEYOND;
      end
      default: ;
    endcase
    if (r.status == ST_FULL) full_rejects++;
    r.count = tbl_count[4:0];
    return r;
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [31:0] key,
                           input logic [31:0] val, input logic [3:0] pos);
    while (in_idle_en && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_in <= key;
    in_value_in <= val;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(table_apply(op, key, val, pos));
    items_sent++;
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        err_count++;
      end else begin
        exp_head = expected_q.pop_front();
        check_field("status", 32'(exp_head.status), 32'(out_status));
        check_field("found", 32'(exp_head.found), 32'(out_found));
        check_field("key_out", exp_head.key, out_key_out);
        check_field("value_out", exp_head.value, out_value_out);
        check_field("insert_number", 32'(exp_head.number), 32'(out_insert_number));
        check_field("entry_count", 32'(exp_head.count), 32'(out_entry_count));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= out_idle_en && ($urandom_range(0, 99) < 33);
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  task automatic test_empty_table();
    send_item(OP_LOOKUP, 32'h0, 32'h0, 4'd0);
    send_item(OP_DELETE, 32'hFFFF_FFFF, 32'h0, 4'd0);
    send_item(OP_READ, 32'h0, 32'h0, 4'd0);
    send_item(OP_READ, 32'h0, 32'h0, 4'd15);
  endtask

  task automatic test_store_update();
    send_item(OP_STORE, 32'h0, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_STORE, 32'hFFFF_FFFF, 32'h0, 4'd0);
    send_item(OP_STORE, 32'h0, 32'h1234_5678, 4'd0);
    send_item(OP_APPEND, 32'h0, 32'hA5A5_A5A5, 4'd0);
    send_item(OP_LOOKUP, 32'h0, 32'h0, 4'd0);
  endtask

  task automatic test_fill_to_full();
    while (tbl_count < DEPTH) send_item(OP_APPEND, $urandom, $urandom, 4'd0);
    send_item(OP_STORE, 32'hDEAD_0001, $urandom, 4'd0);
    send_item(OP_APPEND, 32'h0, $urandom, 4'd0);
    send_item(OP_READ, 32'h0, 32'h0, 4'd15);
  endtask

  task automatic test_delete_renumber();
    send_item(OP_DELETE, 32'h0, 32'h0, 4'd0);
    send_item(OP_READ, 32'h0, 32'h0, 4'd0);
    send_item(OP_APPEND, 32'h5555_AAAA, 32'hAAAA_5555, 4'd0);
  endtask

  task automatic test_spare_opcodes();
    send_item(OP_SPARE_6, $urandom, $urandom, 4'($urandom_range(0, 15)));
    send_item(OP_SPARE_7, $urandom, $urandom, 4'($urandom_range(0, 15)));
    send_item(OP_CLEAR, 32'h0, 32'h0, 4'd0);
    send_item(OP_READ, 32'h0, 32'h0, 4'd0);
  endtask

  task automatic random_items(input int n);
    int sel;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) op = OP_STORE;
      else if (sel < 45) op = OP_APPEND;
      else if (sel < 62) op = OP_LOOKUP;
      else if (sel < 77) op = OP_DELETE;
      else if (sel < 92) op = OP_READ;
      else if (sel < 95) op = OP_CLEAR;
      else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
      send_item(op, pick_key(), $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_random_traffic();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    random_items(600);
    // back-to-back stretch: no gaps on either side
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    random_items(400);
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    random_items(800);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_store_update();
    test_fill_to_full();
    test_delete_renumber();
    test_spare_opcodes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d operations over all eight opcodes, checked %0d results.",
             items_sent, results_seen);
    $display("Table filled to capacity %0d times over, %0d deletes removed an entry.",
             full_rejects, delete_hits);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/lkv_pkg.sv
design/lkv_cell.sv
design/linear_key_value_table.sv
tb/tb_linear_key_value_table.sv
